@@ src/bdp_pkg.sv @@
// Shared types and constants for the delta patch parser.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bdp_pkg;

    // Parse phase of the patch stream
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_OPCODE,
        PH_COPY_OFF,
        PH_COPY_LEN,
        PH_ADD_LEN,
        PH_PAYLOAD,
        PH_DIGEST
    } phase_t;

    // Top two bits of an opcode byte
    localparam logic [1:0] OP_COPY  = 2'd0;
    localparam logic [1:0] OP_CKSUM = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_COPY  = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TRUNCATED = 2'd1;
    localparam logic [1:0] ERR_BAD_CKSUM = 2'd2;

    // Field counter width, long field size, short length bias, highest checksum type
    localparam int unsigned FBL_W            = 5;
    localparam logic [4:0]  LONG_FIELD_BYTES = 5'd4;
    localparam logic [31:0] SHORT_LEN_BIAS   = 32'd5;
    localparam logic [5:0]  CKSUM_TYPE_MAX   = 6'd1;

    // Result channel packing
    localparam int unsigned M_TDATA_W = 144;
    localparam int unsigned M_PAD_W   = 6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] off;
        logic [31:0] len;
        logic [63:0] opos;
        logic [7:0]  sid;
        logic [1:0]  err;
        logic        last;
    } result_t;

    // Results produced by one parsed byte, handed to the output buffer
    typedef struct packed {
        logic       load;
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

`default_nettype wire

@@ src/binary_delta_patch_parser.sv @@
// Top level of the delta patch parser: input register and decode, then result buffer.
// Depends on bdp_pkg, bdp_parser and bdp_out_buf.
//
// Parses a delta patch one byte per transaction and emits one result per copy or add
// command, an error result on a bad checksum type, and an end or truncation result on
// the last byte of a patch not stopped by an error. A byte is taken every cycle
// while results drain at the same rate; a byte that yields two results (a command
// finished on the final byte, followed by the end result) holds the input until the
// first drains, as the two-slot result register drains one result per cycle while
// m_tready is high. No clearing pass is needed after reset. The user must write
// source_tag through cfg_we/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none

module binary_delta_patch_parser #(
    parameter int unsigned HEADER_BYTES = 10,
    parameter int unsigned DIGEST_BYTES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] patch_byte
    input  logic                          s_tlast,   // end_of_patch
    input  logic                          cfg_we,
    input  logic [7:0]                    cfg_wdata, // source_tag
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] offset, [63:32] length, [127:64] output_position, [135:128] source_id,
    // [137:136] error_code, [143:138] zero
    output logic [bdp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser,   // [1:0] result_kind
    output logic                          m_tlast    // last_of_run
);
    import bdp_pkg::*;

    result_pair_t pair;
    logic         out_room;

    bdp_parser #(
        .HEADER_BYTES (HEADER_BYTES),
        .DIGEST_BYTES (DIGEST_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_room  (out_room),
        .pair      (pair)
    );

    bdp_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pair     (pair),
        .out_room (out_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ src/bdp_parser.sv @@
// Input register, parse state and per-byte decode of the delta patch parser.
// Depends on bdp_pkg; feeds bdp_out_buf with up to two results per byte.
`default_nettype none

module bdp_parser #(
    parameter int unsigned HEADER_BYTES = 10,
    parameter int unsigned DIGEST_BYTES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  logic                 out_room,
    output bdp_pkg::result_pair_t pair
);
    import bdp_pkg::*;

    localparam logic [FBL_W-1:0] HDR_LEN     = FBL_W'(HEADER_BYTES);
    localparam phase_t           START_PHASE = (HEADER_BYTES == 0) ? PH_OPCODE : PH_HEADER;
    localparam logic [31:0]      DIGEST_LEN  = 32'(DIGEST_BYTES);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_eop_reg;
    logic [7:0]       source_tag_reg;
    phase_t           phase_reg, phase_next, phase_adv;
    logic [31:0]      pos_reg, pos_next, pos_adv;
    logic [FBL_W-1:0] fbl_reg, fbl_next, fbl_adv;
    logic [31:0]      shift_reg, shift_next, shift_adv;
    logic [31:0]      coff_reg, coff_next, coff_adv;
    logic [5:0]       slen_reg, slen_next, slen_adv;
    logic [31:0]      pleft_reg, pleft_next, pleft_adv;
    logic [63:0]      run_reg, run_next, run_after;
    logic             stop_reg, stop_next, stop_adv;

    logic             s_accept, step;
    logic [1:0]       top;
    logic [5:0]       low;
    logic [31:0]      shifted, pos_inc;
    logic [FBL_W-1:0] fbl_dec;
    logic [31:0]      pleft_dec;
    logic             field_done, pleft_done;

    logic             cmd_valid, bad_ck;
    logic [1:0]       cmd_kind;
    logic [31:0]      cmd_off, cmd_len;
    logic             head_valid, tail_valid, trunc;
    result_t          head, tail;

    // Advance one byte when the output buffer will be free
    assign step     = in_valid_reg && out_room;
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next = s_accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    // Byte fields and counter decrements
    assign top        = in_byte_reg[7:6];
    assign low        = in_byte_reg[5:0];
    assign shifted    = {shift_reg[23:0], in_byte_reg};
    assign pos_inc    = pos_reg + 32'd1;
    assign fbl_dec    = (fbl_reg != '0) ? fbl_reg - 1'b1 : fbl_reg;
    assign field_done = (fbl_dec == '0);
    assign pleft_dec  = (pleft_reg != '0) ? pleft_reg - 32'd1 : pleft_reg;
    assign pleft_done = (pleft_dec == '0);

    // Decode the command finished by this byte
    always_comb begin
        cmd_valid = 1'b0;
        cmd_kind  = KIND_COPY;
        cmd_off   = coff_reg;
        cmd_len   = '0;
        bad_ck    = 1'b0;
        if (!stop_reg) begin
            case (phase_reg)
                PH_OPCODE: begin
                    if (top == OP_ADD && low != '0) begin
                        cmd_valid = 1'b1;
                        cmd_kind  = KIND_ADD;
                        cmd_off   = pos_inc;
                        cmd_len   = 32'(low) + SHORT_LEN_BIAS;
                    end
                    if (top == OP_CKSUM && low > CKSUM_TYPE_MAX) begin
                        bad_ck = 1'b1;
                    end
                end
                PH_COPY_OFF: begin
                    if (field_done && slen_reg != '0) begin
                        cmd_valid = 1'b1;
                        cmd_off   = shifted;
                        cmd_len   = 32'(slen_reg) + SHORT_LEN_BIAS;
                    end
                end
                PH_COPY_LEN: begin
                    if (field_done) begin
                        cmd_valid = 1'b1;
                        cmd_len   = shifted;
                    end
                end
                PH_ADD_LEN: begin
                    if (field_done) begin
                        cmd_valid = 1'b1;
                        cmd_kind  = KIND_ADD;
                        cmd_off   = pos_inc;
                        cmd_len   = shifted;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign run_after = run_reg + (cmd_valid ? {32'd0, cmd_len} : 64'd0);

    // Next parse state for this byte
    always_comb begin
        phase_adv = phase_reg;
        fbl_adv   = fbl_reg;
        shift_adv = shift_reg;
        coff_adv  = coff_reg;
        slen_adv  = slen_reg;
        pleft_adv = pleft_reg;
        stop_adv  = stop_reg;
        pos_adv   = pos_reg;
        if (!stop_reg) begin
            pos_adv = pos_inc;
            case (phase_reg)
                PH_HEADER: begin
                    fbl_adv = fbl_dec;
                    if (field_done) begin
                        phase_adv = PH_OPCODE;
                    end
                end
                PH_OPCODE: begin
                    case (top)
                        OP_COPY: begin
                            slen_adv  = low;
                            shift_adv = '0;
                            fbl_adv   = LONG_FIELD_BYTES;
                            phase_adv = PH_COPY_OFF;
                        end
                        OP_ADD: begin
                            if (low != '0) begin
                                pleft_adv = cmd_len;
                                phase_adv = PH_PAYLOAD;
                            end else begin
                                shift_adv = '0;
                                fbl_adv   = LONG_FIELD_BYTES;
                                phase_adv = PH_ADD_LEN;
                            end
                        end
                        OP_CKSUM: begin
                            if (bad_ck) begin
                                stop_adv = 1'b1;
                            end else begin
                                pleft_adv = DIGEST_LEN;
                                phase_adv = PH_DIGEST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                PH_COPY_OFF, PH_COPY_LEN, PH_ADD_LEN: begin
                    shift_adv = shifted;
                    fbl_adv   = fbl_dec;
                    if (field_done) begin
                        if (phase_reg == PH_COPY_OFF) begin
                            coff_adv = shifted;
                            if (slen_reg != '0) begin
                                phase_adv = PH_OPCODE;
                            end else begin
                                shift_adv = '0;
                                fbl_adv   = LONG_FIELD_BYTES;
                                phase_adv = PH_COPY_LEN;
                            end
                        end else if (phase_reg == PH_COPY_LEN) begin
                            phase_adv = PH_OPCODE;
                        end else begin
                            pleft_adv = shifted;
                            phase_adv = (shifted != '0) ? PH_PAYLOAD : PH_OPCODE;
                        end
                    end
                end
                PH_PAYLOAD, PH_DIGEST: begin
                    pleft_adv = pleft_dec;
                    if (pleft_done) begin
                        phase_adv = PH_OPCODE;
                    end
                end
                default: begin
                    phase_adv = PH_OPCODE;
                end
            endcase
        end
    end

    // Restart everything but the tag after the last byte of a patch
    assign phase_next = in_eop_reg ? START_PHASE : phase_adv;
    assign pos_next   = in_eop_reg ? '0 : pos_adv;
    assign fbl_next   = in_eop_reg ? HDR_LEN : fbl_adv;
    assign shift_next = in_eop_reg ? '0 : shift_adv;
    assign coff_next  = in_eop_reg ? '0 : coff_adv;
    assign slen_next  = in_eop_reg ? '0 : slen_adv;
    assign pleft_next = in_eop_reg ? '0 : pleft_adv;
    assign run_next   = in_eop_reg ? '0 : run_after;
    assign stop_next  = in_eop_reg ? 1'b0 : stop_adv;

    // Build the command or error result and the end-of-patch result
    assign head_valid = cmd_valid || bad_ck;
    assign tail_valid = in_eop_reg && !stop_adv;
    assign trunc      = phase_adv inside {PH_COPY_OFF, PH_COPY_LEN, PH_ADD_LEN, PH_DIGEST};

    always_comb begin
        head.opos = run_reg;
        head.last = !tail_valid;
        if (cmd_valid) begin
            head.kind = cmd_kind;
            head.off  = cmd_off;
            head.len  = cmd_len;
            head.sid  = (cmd_kind == KIND_COPY) ? source_tag_reg : 8'd0;
            head.err  = ERR_NONE;
        end else begin
            head.kind = KIND_ERROR;
            head.off  = pos_reg;
            head.len  = '0;
            head.sid  = 8'd0;
            head.err  = ERR_BAD_CKSUM;
        end
    end

    always_comb begin
        tail.len  = '0;
        tail.opos = run_after;
        tail.sid  = 8'd0;
        tail.last = 1'b1;
        if (trunc) begin
            tail.kind = KIND_ERROR;
            tail.off  = pos_reg;
            tail.err  = ERR_TRUNCATED;
        end else begin
            tail.kind = KIND_END;
            tail.off  = '0;
            tail.err  = ERR_NONE;
        end
    end

    always_comb begin
        pair.load = step;
        if (head_valid) begin
            pair.first  = head;
            pair.second = tail;
            pair.count  = tail_valid ? 2'd2 : 2'd1;
        end else begin
            pair.first  = tail;
            pair.second = tail;
            pair.count  = tail_valid ? 2'd1 : 2'd0;
        end
    end

    // Input register, tag register and parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            source_tag_reg <= '0;
            phase_reg      <= START_PHASE;
            pos_reg        <= '0;
            fbl_reg        <= HDR_LEN;
            shift_reg      <= '0;
            coff_reg       <= '0;
            slen_reg       <= '0;
            pleft_reg      <= '0;
            run_reg        <= '0;
            stop_reg       <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_we) begin
                source_tag_reg <= cfg_wdata;
            end
            if (step) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                fbl_reg   <= fbl_next;
                shift_reg <= shift_next;
                coff_reg  <= coff_next;
                slen_reg  <= slen_next;
                pleft_reg <= pleft_next;
                run_reg   <= run_next;
                stop_reg  <= stop_next;
            end
        end
    end

    // Capture the byte of each accepted transaction
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_eop_reg  <= s_tlast;
        end
    end

endmodule

`default_nettype wire

@@ src/bdp_out_buf.sv @@
// Two-slot result register of the delta patch parser, drives the result stream.
// Depends on bdp_pkg; loaded by bdp_parser.
`default_nettype none

module bdp_out_buf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bdp_pkg::result_pair_t         pair,
    output logic                          out_room,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bdp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);
    import bdp_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    assign pop      = (count_reg != 2'd0) && m_tready;
    assign out_room = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);

    // Load a fresh pair, or shift the second slot forward on a transaction
    always_comb begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pair.load) begin
            count_next = pair.count;
            slot0_next = pair.first;
            slot1_next = pair.second;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Pack the head slot onto the stream
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tuser  = slot0_reg.kind;
    assign m_tlast  = slot0_reg.last;
    assign m_tdata  = {{M_PAD_W{1'b0}}, slot0_reg.err, slot0_reg.sid, slot0_reg.opos,
                       slot0_reg.len, slot0_reg.off};

endmodule

`default_nettype wire

@@ src/bdp_checker.sv @@
// Port-level checks for the delta patch parser, bound to the top level.
// Depends on bdp_pkg and binary_delta_patch_parser.
`default_nettype none

module bdp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bdp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser,
    input logic                          m_tlast
);
    import bdp_pkg::*;

    // Result stream is empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Error code is set exactly on error results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == KIND_ERROR) == (m_tdata[137:136] != ERR_NONE)))
        else $error("error code does not match result kind");

    // End and error results close the run and carry no length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_END || m_tuser == KIND_ERROR)
        |-> m_tlast && m_tdata[63:32] == 32'd0)
        else $error("end or error result not last or has length");

    // Only copy results carry a source id
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_COPY |-> m_tdata[135:128] == 8'd0)
        else $error("source id on non-copy result");

endmodule

bind binary_delta_patch_parser bdp_checker u_bdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
